@@ hw/rtl/utjs_pkg.sv @@
package utjs_pkg;

  // DFA states of note; states 2..8 are inside a multi-byte sequence
  localparam logic [3:0] ST_ACCEPT = 4'd0;
  localparam logic [3:0] ST_REJECT = 4'd1;

  // Kind of pending output job
  localparam logic [1:0] KIND_RAW = 2'd0;
  localparam logic [1:0] KIND_ESC = 2'd1;
  localparam logic [1:0] KIND_UNI = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // One decoded code point waiting to be written out as characters
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  chr;   // raw byte or escape letter
    logic [20:0] cp;
    logic [3:0]  cnt;   // number of characters, 1..8
  } job_t;

  // UTF-8 byte class
  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    priority if (b < 8'd128) c = 4'd0;
    else if (b < 8'd144) c = 4'd1;
    else if (b < 8'd160) c = 4'd9;
    else if (b < 8'd192) c = 4'd7;
    else if (b < 8'd194) c = 4'd8;
    else if (b < 8'd224) c = 4'd2;
    else if (b == 8'd224) c = 4'd10;
    else if (b == 8'd237) c = 4'd4;
    else if (b < 8'd240) c = 4'd3;
    else if (b == 8'd240) c = 4'd11;
    else if (b < 8'd244) c = 4'd6;
    else if (b == 8'd244) c = 4'd5;
    else c = 4'd8;
    return c;
  endfunction

  // DFA transition table, one row of 16 nibbles per state, class 0 lowest
  function automatic logic [3:0] dfa_next(input logic [3:0] st, input logic [3:0] cls);
    logic [63:0] row;
    unique case (st)
      4'd0:    row = 64'h1111_6411_1785_3210;
      4'd2:    row = 64'h1111_1101_0111_1101;
      4'd3:    row = 64'h1111_1121_2111_1121;
      4'd4:    row = 64'h1111_1111_2111_1111;
      4'd5:    row = 64'h1111_1121_1111_1121;
      4'd6:    row = 64'h1111_1131_3111_1111;
      4'd7:    row = 64'h1111_1131_3111_1131;
      4'd8:    row = 64'h1111_1111_1111_1131;
      default: row = 64'h1111_1111_1111_1111;
    endcase
    return row[{cls, 2'b00} +: 4];
  endfunction

  // Uppercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
  endfunction

endpackage

@@ hw/rtl/utjs_dfa.sv @@
module utjs_dfa
  import utjs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       first_byte,
  output logic       job_valid,
  output job_t       job
);

  logic [3:0]  dfa_state;
  logic [20:0] cp_acc;
  logic [3:0]  dfa_state_next;
  logic [20:0] cp_acc_next;
  logic [3:0]  st_cur;
  logic [20:0] cp_cur;
  logic [3:0]  cls;
  logic [7:0]  esc;

  // Decode one byte against the held state
  always_comb begin
    st_cur = first_byte ? ST_ACCEPT : dfa_state;
    cp_cur = first_byte ? 21'd0 : cp_acc;
    cls    = byte_class(in_byte);
    if (st_cur != ST_ACCEPT) begin
      cp_acc_next = {cp_cur[14:0], in_byte[5:0]};
    end else begin
      cp_acc_next = {13'd0, (8'hFF >> cls) & in_byte};
    end
    dfa_state_next = dfa_next(st_cur, cls);
  end

  // Pick the escape letter for ASCII code points
  always_comb begin
    unique case (cp_acc_next[6:0])
      7'h07:   esc = 8'h61;
      7'h08:   esc = 8'h62;
      7'h09:   esc = 8'h74;
      7'h0A:   esc = 8'h6E;
      7'h0B:   esc = 8'h76;
      7'h0C:   esc = 8'h66;
      7'h0D:   esc = 8'h72;
      7'h5C:   esc = CH_BSLASH;
      7'h22:   esc = 8'h22;
      default: esc = 8'h00;
    endcase
  end

  // Build the output job
  always_comb begin
    job.cp  = cp_acc_next;
    job.chr = in_byte;
    if (cp_acc_next > 21'd127) begin
      job.kind = KIND_UNI;
      if (cp_acc_next > 21'hFFFFF) begin
        job.cnt = 4'd8;
      end else if (cp_acc_next > 21'hFFFF) begin
        job.cnt = 4'd7;
      end else begin
        job.cnt = 4'd6;
      end
    end else if (esc != 8'h00) begin
      job.kind = KIND_ESC;
      job.chr  = esc;
      job.cnt  = 4'd2;
    end else begin
      job.kind = KIND_RAW;
      job.cnt  = 4'd1;
    end
  end

  assign job_valid = accept && (dfa_state_next == ST_ACCEPT);

  // Advance decoder state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      dfa_state <= ST_ACCEPT;
      cp_acc    <= 21'd0;
    end else if (accept) begin
      dfa_state <= dfa_state_next;
      cp_acc    <= cp_acc_next;
    end
  end

endmodule

@@ hw/rtl/utjs_emit.sv @@
module utjs_emit
  import utjs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job_in,
  output logic       slot_free,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  logic       busy;
  job_t       job;
  logic [2:0] idx;
  logic       out_load;
  logic       last;
  logic [2:0] pos;
  logic [3:0] pos_full;
  logic [23:0] cp24;
  logic [3:0] nib;
  logic [7:0] chr;

  assign out_load  = busy && (!m_tvalid || m_tready);
  assign last      = ({1'b0, idx} == (job.cnt - 4'd1));
  assign slot_free = !busy || (out_load && last);

  // Select the character at the current index
  always_comb begin
    pos_full = job.cnt - 4'd1 - {1'b0, idx};
    pos      = pos_full[2:0];
    cp24     = {3'd0, job.cp};
    nib      = 4'(cp24 >> {pos, 2'b00});
    unique case (job.kind)
      KIND_UNI: begin
        if (idx == 3'd0) begin
          chr = CH_BSLASH;
        end else if (idx == 3'd1) begin
          chr = CH_LOW_U;
        end else begin
          chr = hex_char(nib);
        end
      end
      KIND_ESC: chr = (idx == 3'd0) ? CH_BSLASH : job.chr;
      default:  chr = job.chr;
    endcase
  end

  // Hold the job and step through its characters
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (job_valid) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (out_load) begin
      if (last) begin
        busy <= 1'b0;
      end
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid) begin
      job <= job_in;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= chr;
      m_tlast <= last;
    end
  end

endmodule

@@ hw/rtl/utf8_to_json_escaped_chars_top.sv @@
// Channel | Signals                         | Payload
// in      | s_tvalid s_tready s_tdata s_tuser | tdata[7:0] in_byte, tuser[0] first_byte
// out     | m_tvalid m_tready m_tdata m_tlast | tdata[7:0] out_char, tlast last_char
//
// A byte is decoded in the cycle it is taken; its characters leave one per cycle while the output
// is not stalled, passing through a job register and then an output register.
// A byte that completes a code point makes a job of 1 to 8 characters; other bytes make none.
// Reset clears the decoder to the accept state and empties both registers.
// Output stalls hold the output register; input waits only while a job is
// still being written out.
module utf8_to_json_escaped_chars_top
  import utjs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tuser,   // [0] first_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast
);

  logic accept;
  logic job_valid;
  job_t job;
  logic slot_free;

  assign s_tready = slot_free;
  assign accept   = s_tvalid && s_tready;

  utjs_dfa u_dfa (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (s_tdata),
    .first_byte (s_tuser),
    .job_valid  (job_valid),
    .job        (job)
  );

  utjs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_in    (job),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
